FILE: design/fskf_pkg.sv
// shared constants and types for the first-seen key filter
`timescale 1ns / 1ps
`default_nettype none

package fskf_pkg;

    // table size, a power of two so the slot index is the low key bits
    localparam int TABLE_SLOTS = 4096;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int KEY_W       = 64;
    localparam int OUT_DATA_W  = 8;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } t_state;

endpackage

`default_nettype wire

FILE: design/fskf_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module fskf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/first_seen_key_filter_core.sv
// top level of the first-seen key filter: hash set with linear probing
// the key is registered when taken, then the table is probed one slot per cycle; the result is registered
// one key at a time: a new key is taken only after the last lookup has put its result in the output register
// the probe rate is set by the registered read data of the slot table memory
// reset: synchronous active low; a clearing pass then writes 4096 empty slots, one per cycle,
// and no key is accepted until it ends
`timescale 1ns / 1ps
`default_nettype none

module first_seen_key_filter_core
    import fskf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [KEY_W-1:0]      i_s_axis_tdata,   // [63:0] key
    // result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [OUT_DATA_W-1:0] o_m_axis_tdata    // [0] first_seen, [1] table_full, rest 0
);

    // fsm state
    t_state r_state, n_state;

    // working registers of the current lookup
    t_key  r_key, n_key;            // key after zero is mapped to one
    t_slot r_slot, n_slot;          // slot whose read data the table holds
    t_slot r_count, n_count;        // probes done so far, minus one
    t_slot r_clear_addr, n_clear_addr;

    // output register
    logic r_out_valid, n_out_valid;
    logic r_first, n_first;
    logic r_full, n_full;

    // table memory port
    logic  ram_wr_en;
    t_slot ram_wr_addr;
    t_key  ram_wr_data;
    logic  ram_rd_en;
    t_slot ram_rd_addr;
    t_key  ram_rd_data;

    // decode of the slot just read
    logic  in_take;
    t_key  in_key;
    logic  slot_empty;
    logic  slot_match;
    logic  chain_last;
    logic  probe_done;
    logic  out_free;

    fskf_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    // key zero shares the member of key one, zero marks an empty slot
    assign in_key          = (i_s_axis_tdata == '0) ? t_key'(1) : i_s_axis_tdata;

    assign slot_empty = (ram_rd_data == '0);
    assign slot_match = (ram_rd_data == r_key);
    assign chain_last = (r_count == t_slot'(TABLE_SLOTS - 1));
    assign probe_done = slot_empty || slot_match || chain_last;
    // the result register can take a new transaction this cycle
    assign out_free   = !r_out_valid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clear_addr == t_slot'(TABLE_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (probe_done && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_key        = r_key;
        n_slot       = r_slot;
        n_count      = r_count;
        n_clear_addr = r_clear_addr;
        n_first      = r_first;
        n_full       = r_full;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_slot;
        ram_wr_data  = r_key;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_slot;
        unique case (r_state)
            ST_CLEAR: begin
                // sweep the table to all empty
                ram_wr_en    = 1'b1;
                ram_wr_addr  = r_clear_addr;
                ram_wr_data  = '0;
                n_clear_addr = r_clear_addr + t_slot'(1);
            end
            ST_IDLE: begin
                // start slot is the key modulo the table size
                if (in_take) begin
                    n_key       = in_key;
                    n_slot      = in_key[SLOT_W-1:0];
                    n_count     = '0;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = in_key[SLOT_W-1:0];
                end
            end
            ST_PROBE: begin
                if (probe_done) begin
                    // hold the read data until the result register frees up
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        if (slot_empty) begin
                            ram_wr_en = 1'b1;
                            n_first   = 1'b1;
                            n_full    = 1'b0;
                        end else if (slot_match) begin
                            n_first = 1'b0;
                            n_full  = 1'b0;
                        end else begin
                            // every slot held some other key, nothing is stored
                            n_first = 1'b1;
                            n_full  = 1'b1;
                        end
                    end
                end else begin
                    // step to the next slot, wrapping at the table end
                    n_slot      = r_slot + t_slot'(1);
                    n_count     = r_count + t_slot'(1);
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_slot + t_slot'(1);
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clear_addr <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clear_addr <= n_clear_addr;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_slot  <= n_slot;
        r_count <= n_count;
        r_first <= n_first;
        r_full  <= n_full;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - 2){1'b0}}, r_full, r_first};

endmodule

`default_nettype wire

FILE: tb/first_seen_key_filter_core_tb.sv
// testbench for the first-seen key filter: shadow key set, directed and random keys
`timescale 1ns / 1ps

module first_seen_key_filter_core_tb;
    import fskf_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int IDLE_PCT       = 24;
    localparam int RANDOM_KEYS    = 1200;
    localparam int HISTORY_DEPTH  = 512;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int FIRST_SEEN_BIT = 0;
    localparam int TABLE_FULL_BIT = 1;

    // chain, wrap and zero-key cases on an empty table
    localparam t_key DIRECTED_KEYS [16] = '{
        64'h0000_0000_0000_0000,    // zero key, stored as one
        64'h0000_0000_0000_0001,    // same member as zero
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,    // top slot
        64'hFFFF_FFFF_FFFF_EFFF,    // collides on top slot, wraps to slot 0
        64'h0000_0000_0000_1FFF,    // longer chain across the wrap
        64'h8000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_EFFF,    // present at the end of a chain
        64'h8000_0000_0000_0000,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555,
        64'h0000_0000_0000_1000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'h0000_0000_0000_1FFF
    };

    typedef struct packed {
        logic first_seen;
        logic table_full;
    } t_verdict;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    t_key                  i_s_axis_tdata  = '0;   // [63:0] key
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;         // [0] first_seen, [1] table_full

    bit no_idle = 1'b0;
    int cycle_count = 0;

    first_seen_key_filter_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // shadow copy of the key table and the verdicts still owed by the block
    class first_seen_checker;
        bit [KEY_W-1:0] shadow_slots [TABLE_SLOTS];
        t_verdict       pending_verdicts [$];
        int unsigned    mismatches;

        // walk the probe chain exactly as the block should, then queue the verdict
        function void note_key(t_key key);
            t_key     member;
            t_slot    slot;
            t_verdict verdict;
            bit       done;
            member             = (key == '0) ? t_key'(1) : key;
            verdict.first_seen = 1'b1;
            verdict.table_full = 1'b1;
            done               = 1'b0;
            for (int probe = 0; probe < TABLE_SLOTS && !done; probe++) begin
                slot = t_slot'(member) + t_slot'(probe);
                if (shadow_slots[slot] == '0) begin
                    shadow_slots[slot] = member;
                    verdict.table_full = 1'b0;
                    done               = 1'b1;
                end else if (shadow_slots[slot] == member) begin
                    verdict.first_seen = 1'b0;
                    verdict.table_full = 1'b0;
                    done               = 1'b1;
                end
            end
            pending_verdicts.push_back(verdict);
        endfunction

        function void check_verdict(logic [OUT_DATA_W-1:0] data);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result transaction, tdata=%0h", data);
                return;
            end
            want = pending_verdicts.pop_front();
            if (data[FIRST_SEEN_BIT] !== want.first_seen ||
                data[TABLE_FULL_BIT] !== want.table_full) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected first_seen=%0b table_full=%0b, got %0b %0b",
                             want.first_seen, want.table_full,
                             data[FIRST_SEEN_BIT], data[TABLE_FULL_BIT]);
            end
        endfunction
    endclass

    first_seen_checker tracker = new();

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk)
        i_m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge i_clk)
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_verdict(o_m_axis_tdata);

    function automatic t_key random_key();
        return {$urandom(), $urandom()};
    endfunction

    // one key transaction, with an occasional gap in front of it
    task automatic send_key(input t_key key);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= key;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_key(key);
    endtask

    task automatic wait_all_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_verdicts.size() != 0);
    endtask

    initial begin
        t_key history [$];
        t_key key;
        int   pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_KEYS[i]) begin
            send_key(DIRECTED_KEYS[i]);
            history.push_back(DIRECTED_KEYS[i]);
        end

        // mixed new keys, repeats and slot clusters that build probe chains
        for (int n = 0; n < RANDOM_KEYS; n++) begin
            no_idle = (n >= 500 && n < 800);
            if (n == 650)
                wait_all_results();
            pick = $urandom_range(99);
            if (pick < 35) begin
                key = history[$urandom_range(history.size() - 1)];
            end else if (pick < 75) begin
                key = random_key();
            end else if (pick < 90) begin
                key = random_key();
                key[SLOT_W-1:0] = $urandom_range(1) ? t_slot'($urandom_range(31))
                                                    : t_slot'($urandom_range(4064, 4095));
            end else if (pick < 95) begin
                key = t_key'($urandom_range(1));
            end else begin
                key = t_key'(1) << $urandom_range(KEY_W - 1);
                if ($urandom_range(1))
                    key = ~key;
            end
            send_key(key);
            if (history.size() < HISTORY_DEPTH)
                history.push_back(key);
            else
                history[$urandom_range(HISTORY_DEPTH - 1)] = key;
        end
        no_idle = 1'b0;

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
